// ----- sv/mu8dec_pkg.sv -----
package mu8dec_pkg;

   // Width of the running count of nonzero units.
   localparam int COUNT_WIDTH = 16;

   // Result queue between the decoder and the response port.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // Surrogate offsets.
   localparam logic [15:0] HIGH_SURROGATE_BASE = 16'hd7c0;
   localparam logic [5:0]  LOW_SURROGATE_TAG   = 6'b110111;

   typedef struct packed {
      logic [15:0] utf16_unit;
      logic        has_unit;
      logic [15:0] unit_count;
      logic        end_of_string;
      logic        truncated;
   } rsp_type;

   // Results produced by one byte: zero, one or two, first in r0.
   typedef struct packed {
      logic [1:0] num;
      rsp_type    r0;
      rsp_type    r1;
   } decode_type;

   // Report the count, saturated to 16 bits.
   function automatic logic [15:0] count_show(input logic [COUNT_WIDTH-1:0] cnt);
      logic [COUNT_WIDTH+15:0] wide;
      wide = {16'b0, cnt};
      if (wide > (COUNT_WIDTH + 16)'(16'hffff)) begin
         return 16'hffff;
      end
      return wide[15:0];
   endfunction

   // Count a unit if it is nonzero; hold at the maximum.
   function automatic logic [COUNT_WIDTH-1:0] count_bump(input logic [COUNT_WIDTH-1:0] cnt,
                                                         input logic [15:0] unit);
      if (unit != 16'h0000 && cnt != {COUNT_WIDTH{1'b1}}) begin
         return cnt + COUNT_WIDTH'(1);
      end
      return cnt;
   endfunction

endpackage

// ----- sv/mu8dec_core.sv -----
module mu8dec_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  logic [7:0]              in_byte,
   input  logic                    last_byte,
   output mu8dec_pkg::decode_type  dec
);

   logic [23:0]                        gathered_ff, gathered_in;
   logic [1:0]                         seq_len_ff, seq_len_in;
   logic [1:0]                         seen_ff, seen_in;
   logic [mu8dec_pkg::COUNT_WIDTH-1:0] count_ff, count_in;

   logic [1:0]                         len_m1;
   logic [7:0]                         b1, b2, b3;
   logic [21:0]                        cp;
   logic [15:0]                        hi, lo;
   logic [mu8dec_pkg::COUNT_WIDTH-1:0] cnt_hi, cnt_lo;
   mu8dec_pkg::decode_type             dec_c;

   always_comb begin
      gathered_in = gathered_ff;
      seq_len_in  = seq_len_ff;
      seen_in     = seen_ff;
      count_in    = count_ff;
      dec_c       = '0;
      b1          = 8'h00;
      b2          = 8'h00;
      b3          = 8'h00;
      hi          = 16'h0000;
      lo          = 16'h0000;

      // Length minus one of the open sequence, from the lead byte when none is open.
      if (seen_ff != 2'd0) begin
         len_m1 = seq_len_ff;
      end else if (!in_byte[7]) begin
         len_m1 = 2'd0;
      end else if (!in_byte[5]) begin
         len_m1 = 2'd1;
      end else if (!in_byte[4]) begin
         len_m1 = 2'd2;
      end else begin
         len_m1 = 2'd3;
      end

      // Pick out the bytes of the sequence.
      unique case (len_m1)
         2'd0: begin
            b1 = in_byte;
         end
         2'd1: begin
            b1 = gathered_ff[7:0];
            b2 = in_byte;
         end
         2'd2: begin
            b1 = gathered_ff[15:8];
            b2 = gathered_ff[7:0];
            b3 = in_byte;
         end
         default: begin
            b1 = gathered_ff[23:16];
            b2 = gathered_ff[15:8];
            b3 = gathered_ff[7:0];
         end
      endcase

      cp = {b1[3:0], b2[5:0], b3[5:0], in_byte[5:0]};

      unique case (len_m1)
         2'd0: hi = {8'h00, b1};
         2'd1: hi = {5'b0, b1[4:0], b2[5:0]};
         2'd2: hi = {b1[3:0], b2[5:0], b3[5:0]};
         default: begin
            hi = {4'b0, cp[21:10]} + mu8dec_pkg::HIGH_SURROGATE_BASE;
            lo = {mu8dec_pkg::LOW_SURROGATE_TAG, cp[9:0]};
         end
      endcase

      cnt_hi = mu8dec_pkg::count_bump(count_ff, hi);
      cnt_lo = mu8dec_pkg::count_bump(cnt_hi, lo);

      if (seen_ff < len_m1) begin
         // Sequence still open: gather the byte.
         gathered_in = {gathered_ff[15:0], in_byte};
         seq_len_in  = len_m1;
         seen_in     = seen_ff + 2'd1;
         if (last_byte) begin
            // String ended mid-sequence: drop the partial bytes, send a bare marker.
            dec_c.num              = 2'd1;
            dec_c.r0.unit_count    = mu8dec_pkg::count_show(count_ff);
            dec_c.r0.end_of_string = 1'b1;
            dec_c.r0.truncated     = 1'b1;
            gathered_in = '0;
            seq_len_in  = '0;
            seen_in     = '0;
            count_in    = '0;
         end
      end else begin
         gathered_in = '0;
         seq_len_in  = '0;
         seen_in     = '0;
         dec_c.r0.utf16_unit = hi;
         dec_c.r0.has_unit   = 1'b1;
         dec_c.r0.unit_count = mu8dec_pkg::count_show(cnt_hi);
         if (len_m1 == 2'd3) begin
            dec_c.num              = 2'd2;
            dec_c.r1.utf16_unit    = lo;
            dec_c.r1.has_unit      = 1'b1;
            dec_c.r1.unit_count    = mu8dec_pkg::count_show(cnt_lo);
            dec_c.r1.end_of_string = last_byte;
            count_in               = cnt_lo;
         end else begin
            dec_c.num              = 2'd1;
            dec_c.r0.end_of_string = last_byte;
            count_in               = cnt_hi;
         end
         if (last_byte) begin
            count_in = '0;
         end
      end
   end

   assign dec = dec_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         gathered_ff <= '0;
         seq_len_ff  <= '0;
         seen_ff     <= '0;
         count_ff    <= '0;
      end else if (fire) begin
         gathered_ff <= gathered_in;
         seq_len_ff  <= seq_len_in;
         seen_ff     <= seen_in;
         count_ff    <= count_in;
      end
   end

endmodule

// ----- sv/modified_utf8_to_utf16_decoder_unit.sv -----
// Modified UTF-8 to UTF-16 decoder.
//
// Request channel (req_*): one byte of the string per request, with
// req_last_byte marking the final byte. A request is taken at a clock edge
// where req_valid is high and req_stall is low.
// Response channel (rsp_*): one UTF-16 unit per response, with the running
// count of nonzero units, an end-of-string flag and a truncated flag. A byte
// that closes a four-byte sequence gives two responses (high surrogate, then
// low surrogate); a byte inside an open sequence gives none, unless it is the
// final byte, which then gives one bare end marker with truncated set.
//
// Throughput: one byte per cycle, sustained, as long as the receiver keeps up.
// Path: a request taken at a clock edge passes through the input register,
// then is decoded into the response queue, whose head drives the rsp_* ports
// directly. The four-entry response queue sets the rate: a byte is decoded
// when at least two entries are free.
// Stall: when rsp_stall is high the head response holds; once the queue
// cannot take two more results, req_stall rises and the input register holds.
// Reset: clears the open sequence, the running count and the queue.
module modified_utf8_to_utf16_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_utf16_unit,
   output logic        rsp_has_unit,
   output logic [15:0] rsp_unit_count,
   output logic        rsp_end_of_string,
   output logic        rsp_truncated
);

   localparam int PW = mu8dec_pkg::QUEUE_PTR_WIDTH;
   localparam int CW = mu8dec_pkg::QUEUE_CNT_WIDTH;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Response queue.
   mu8dec_pkg::rsp_type queue_ff [mu8dec_pkg::QUEUE_DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       q_count_ff, q_count_in;
   logic [PW-1:0]       wr_ptr_next;

   mu8dec_pkg::decode_type dec;
   mu8dec_pkg::rsp_type    head;
   logic                   advance;
   logic                   accept;
   logic                   pop;
   logic [CW-1:0]          push_num;

   // Decode only when the queue has room for the largest burst of two.
   assign advance   = in_valid_ff && (q_count_ff <= CW'(mu8dec_pkg::QUEUE_DEPTH - 2));
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   mu8dec_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .in_byte   (in_byte_ff),
      .last_byte (in_last_ff),
      .dec       (dec)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         // Take the next request, or drain the register.
         in_valid_in = req_valid;
      end
   end

   always_comb begin
      push_num    = advance ? CW'(dec.num) : '0;
      wr_ptr_next = wr_ptr_ff + PW'(1);
      wr_ptr_in   = wr_ptr_ff + PW'(push_num);
      rd_ptr_in   = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      q_count_in  = q_count_ff + push_num - (pop ? CW'(1) : CW'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         q_count_ff  <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         q_count_ff  <= q_count_in;
      end
   end

   // Payload registers: no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance && dec.num != 2'd0) begin
         queue_ff[wr_ptr_ff] <= dec.r0;
      end
      if (advance && dec.num == 2'd2) begin
         queue_ff[wr_ptr_next] <= dec.r1;
      end
   end

   // Drive the response ports straight from the queue head.
   assign head              = queue_ff[rd_ptr_ff];
   assign rsp_valid         = (q_count_ff != '0);
   assign rsp_utf16_unit    = head.utf16_unit;
   assign rsp_has_unit      = head.has_unit;
   assign rsp_unit_count    = head.unit_count;
   assign rsp_end_of_string = head.end_of_string;
   assign rsp_truncated     = head.truncated;

endmodule
